// ===== rtl/core/stl_pkg.sv =====
// Shared command codes, result codes and types of the sorted timer list.
`default_nettype none
package stl_pkg;

   // Command codes on req_cmd.
   localparam logic [2:0] CMD_TICK     = 3'd0;
   localparam logic [2:0] CMD_START    = 3'd1;
   localparam logic [2:0] CMD_STOP     = 3'd2;
   localparam logic [2:0] CMD_SET_PER  = 3'd3;
   localparam logic [2:0] CMD_READ_PER = 3'd4;
   localparam logic [2:0] CMD_ONE_SHOT = 3'd5;
   localparam logic [2:0] CMD_PERIODIC = 3'd6;
   localparam logic [2:0] CMD_INVALID  = 3'd7;

   // Result kinds on rsp_kind.
   localparam logic KIND_RESP  = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   // Largest stored period and the cap on expiry beats per tick.
   localparam logic [30:0] PERIOD_MAX  = 31'h7FFF_FFFF;
   localparam int          RES_CNT_W   = 5;
   localparam logic [4:0]  MAX_RESULTS = 5'd16;

   // Flags from the shared subtract and compare unit.
   typedef struct packed {
      logic lt_half;
      logic nonzero;
   } alu_flags_type;

endpackage
`default_nettype wire

// ===== rtl/core/stl_alu.sv =====
// Shared add, subtract and wrap-aware compare unit of the sorted timer list.
`default_nettype none
module stl_alu #(
   parameter int TICK_BITS = 32
) (
   input  wire logic                 op_sub,
   input  wire logic [TICK_BITS-1:0] opa,
   input  wire logic [TICK_BITS-1:0] opb,
   output logic [TICK_BITS-1:0]      res,
   output stl_pkg::alu_flags_type    flags
);

   localparam logic [TICK_BITS-1:0] TICK_HALF = {1'b0, {(TICK_BITS-1){1'b1}}};

   // One adder serves deadline sums and modular differences.
   always_comb begin
      res = op_sub ? (opa - opb) : (opa + opb);
      flags.lt_half = (res < TICK_HALF);
      flags.nonzero = (res != '0);
   end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_timer_list.sv =====
// Top level of the sorted timer list: sequencer, timer state and result port.
//
// Usage: a command is taken on a rising edge with start high and busy low.
// Commands other than tick give exactly one response beat (rsp_kind low,
// rsp_last high). Tick advances time by one and gives zero or more expiry
// beats (rsp_kind high) in deadline order, at most sixteen, the final one
// marked by rsp_last. Each beat is on the rsp_ ports for one cycle under
// rsp_valid; the receiver cannot stall, so beats are never held.
// Set period, read period, mode changes and failed commands answer in the
// cycle after acceptance and leave busy low. Stop walks the list, one
// entry per cycle. Start runs a removal walk if the timer is listed, a
// deadline sum, an ordered insertion walk and the link steps; the sum and
// the insertion walk use the one shared adder and compare unit. A tick
// checks the list head once per expiry and once more to finish, and
// reinserts every periodic timer that fires through the insertion walk.
// Reset clears time, periods, modes and the list; deadlines and links need
// no clearing since they are read only for listed timers.
`default_nettype none
module sorted_timer_list #(
   parameter int NUM_TIMERS = 16,
   parameter int TICK_BITS  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [3:0]  req_timer_id,
   input  wire logic [31:0] req_period_value,
   output logic             busy,
   output logic             rsp_valid,
   output logic             rsp_kind,
   output logic [3:0]       rsp_which_timer,
   output logic [30:0]      rsp_read_period,
   output logic             rsp_failed,
   output logic             rsp_last
);

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam int PW = (TICK_BITS > 31) ? TICK_BITS : 31;
   localparam logic [TICK_BITS-1:0] TICK_HALF = {1'b0, {(TICK_BITS-1){1'b1}}};

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TCHK = 3'd1;
   localparam logic [2:0] S_RM   = 3'd2;
   localparam logic [2:0] S_DL   = 3'd3;
   localparam logic [2:0] S_INS  = 3'd4;
   localparam logic [2:0] S_LNK1 = 3'd5;
   localparam logic [2:0] S_LNK2 = 3'd6;

   // Control state.
   logic [2:0]                  state_ff;
   logic [TICK_BITS-1:0]        now_ff;
   logic [IW-1:0]               head_ff;
   logic [CW-1:0]               count_ff;
   logic [NUM_TIMERS-1:0]       active_ff;
   logic [NUM_TIMERS-1:0]       periodic_ff;
   logic [30:0]                 period_ff [NUM_TIMERS];
   logic [TICK_BITS-1:0]        deadline_ff [NUM_TIMERS];
   logic [IW-1:0]               next_ff [NUM_TIMERS];

   // Sequencer working registers.
   logic [2:0]                  cmd_ff;
   logic [IW-1:0]               id_ff;
   logic [IW-1:0]               cur_ff;
   logic [IW-1:0]               prev_ff;
   logic                        has_prev_ff;
   logic [CW-1:0]               k_ff;
   logic [TICK_BITS-1:0]        dl_ff;
   logic                        from_tick_ff;
   logic                        pend_valid_ff;
   logic [IW-1:0]               pend_id_ff;
   logic [stl_pkg::RES_CNT_W-1:0] n_ff;

   // Result registers.
   logic                        rsp_valid_ff;
   logic                        rsp_kind_ff;
   logic [3:0]                  rsp_which_ff;
   logic [30:0]                 rsp_rp_ff;
   logic                        rsp_failed_ff;
   logic                        rsp_last_ff;

   // Read ports and decoded request.
   logic [IW-1:0]               req_idx;
   logic                        id_ok;
   logic                        cmd_fail;
   logic                        defer_rsp;
   logic [IW-1:0]               rd_idx;
   logic [IW-1:0]               rd_next;
   logic [TICK_BITS-1:0]        rd_dl;
   logic [IW-1:0]               p_idx;
   logic [30:0]                 p_rd;
   logic [PW-1:0]               p_ext;
   logic [TICK_BITS-1:0]        p_eff;
   logic [30:0]                 pv_clamped;

   // Shared unit operands.
   logic                        alu_sub;
   logic [TICK_BITS-1:0]        alu_a;
   logic [TICK_BITS-1:0]        alu_b;
   logic [TICK_BITS-1:0]        alu_res;
   stl_pkg::alu_flags_type      alu_flags;

   // Request decode.
   always_comb begin
      req_idx   = IW'(req_timer_id);
      id_ok     = (int'(req_timer_id) < NUM_TIMERS);
      cmd_fail  = !id_ok || (req_cmd == stl_pkg::CMD_INVALID) ||
                  ((req_cmd == stl_pkg::CMD_STOP) && !active_ff[req_idx]);
      defer_rsp = !cmd_fail && ((req_cmd == stl_pkg::CMD_START) ||
                                (req_cmd == stl_pkg::CMD_STOP));
      if (req_period_value == 32'd0) begin
         pv_clamped = 31'd1;
      end else if (req_period_value[31]) begin
         pv_clamped = stl_pkg::PERIOD_MAX;
      end else begin
         pv_clamped = req_period_value[30:0];
      end
   end

   // Single read address into the deadline and link arrays.
   always_comb begin
      rd_idx  = (state_ff == S_TCHK) ? head_ff : cur_ff;
      rd_next = next_ff[rd_idx];
      rd_dl   = deadline_ff[rd_idx];
      p_idx   = (state_ff == S_IDLE) ? req_idx : id_ff;
      p_rd    = period_ff[p_idx];
   end

   // Effective period: at least one, at most half the tick range.
   always_comb begin
      p_ext = PW'(p_rd);
      if (p_ext == '0) begin
         p_ext = PW'(1);
      end
      if (p_ext > PW'(TICK_HALF)) begin
         p_ext = PW'(TICK_HALF);
      end
      p_eff = p_ext[TICK_BITS-1:0];
   end

   // Operand selection for the shared unit.
   always_comb begin
      case (state_ff)
         S_DL: begin
            alu_sub = 1'b0;
            alu_a   = now_ff;
            alu_b   = p_eff;
         end
         S_INS: begin
            alu_sub = 1'b1;
            alu_a   = rd_dl;
            alu_b   = dl_ff;
         end
         default: begin
            alu_sub = 1'b1;
            alu_a   = now_ff;
            alu_b   = rd_dl;
         end
      endcase
   end

   stl_alu #(
      .TICK_BITS (TICK_BITS)
   ) u_alu (
      .op_sub (alu_sub),
      .opa    (alu_a),
      .opb    (alu_b),
      .res    (alu_res),
      .flags  (alu_flags)
   );

   // Timer state with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         now_ff        <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         active_ff     <= '0;
         periodic_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            period_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cmd_ff       <= req_cmd;
                  id_ff        <= req_idx;
                  cur_ff       <= head_ff;
                  has_prev_ff  <= 1'b0;
                  from_tick_ff <= 1'b0;
                  if (req_cmd == stl_pkg::CMD_TICK) begin
                     now_ff        <= now_ff + 1'b1;
                     n_ff          <= '0;
                     pend_valid_ff <= 1'b0;
                     state_ff      <= S_TCHK;
                  end else begin
                     if (!defer_rsp) begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_kind_ff   <= stl_pkg::KIND_RESP;
                        rsp_which_ff  <= req_timer_id;
                        rsp_rp_ff     <= (!cmd_fail && req_cmd == stl_pkg::CMD_READ_PER) ?
                                         p_rd : 31'd0;
                        rsp_failed_ff <= cmd_fail;
                        rsp_last_ff   <= 1'b1;
                     end
                     if (!cmd_fail) begin
                        case (req_cmd)
                           stl_pkg::CMD_START: begin
                              state_ff <= active_ff[req_idx] ? S_RM : S_DL;
                           end
                           stl_pkg::CMD_STOP: begin
                              state_ff <= S_RM;
                           end
                           stl_pkg::CMD_SET_PER: begin
                              period_ff[req_idx] <= pv_clamped;
                           end
                           stl_pkg::CMD_ONE_SHOT: begin
                              periodic_ff[req_idx] <= 1'b0;
                           end
                           stl_pkg::CMD_PERIODIC: begin
                              periodic_ff[req_idx] <= 1'b1;
                           end
                           default: begin
                           end
                        endcase
                     end
                  end
               end
            end

            // Walk to the timer and unlink it.
            S_RM: begin
               if (cur_ff == id_ff) begin
                  if (has_prev_ff) begin
                     next_ff[prev_ff] <= rd_next;
                  end else begin
                     head_ff <= rd_next;
                  end
                  count_ff <= count_ff - CW'(1);
                  if (cmd_ff == stl_pkg::CMD_STOP) begin
                     active_ff[id_ff] <= 1'b0;
                     rsp_valid_ff     <= 1'b1;
                     rsp_kind_ff      <= stl_pkg::KIND_RESP;
                     rsp_which_ff     <= 4'(id_ff);
                     rsp_rp_ff        <= '0;
                     rsp_failed_ff    <= 1'b0;
                     rsp_last_ff      <= 1'b1;
                     state_ff         <= S_IDLE;
                  end else begin
                     state_ff <= S_DL;
                  end
               end else begin
                  prev_ff     <= cur_ff;
                  cur_ff      <= rd_next;
                  has_prev_ff <= 1'b1;
               end
            end

            // New deadline through the shared adder.
            S_DL: begin
               deadline_ff[id_ff] <= alu_res;
               dl_ff              <= alu_res;
               cur_ff             <= head_ff;
               has_prev_ff        <= 1'b0;
               k_ff               <= '0;
               state_ff           <= S_INS;
            end

            // Skip every entry with an equal or earlier deadline.
            S_INS: begin
               if ((k_ff == count_ff) || (alu_flags.nonzero && alu_flags.lt_half)) begin
                  state_ff <= S_LNK1;
               end else begin
                  prev_ff     <= cur_ff;
                  cur_ff      <= rd_next;
                  has_prev_ff <= 1'b1;
                  k_ff        <= k_ff + CW'(1);
               end
            end

            S_LNK1: begin
               next_ff[id_ff] <= cur_ff;
               state_ff       <= S_LNK2;
            end

            S_LNK2: begin
               if (has_prev_ff) begin
                  next_ff[prev_ff] <= id_ff;
               end else begin
                  head_ff <= id_ff;
               end
               count_ff         <= count_ff + CW'(1);
               active_ff[id_ff] <= 1'b1;
               if (from_tick_ff) begin
                  state_ff <= S_TCHK;
               end else begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_kind_ff   <= stl_pkg::KIND_RESP;
                  rsp_which_ff  <= 4'(id_ff);
                  rsp_rp_ff     <= '0;
                  rsp_failed_ff <= 1'b0;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end

            // Check the head; an expiry beat is held until the next head check so that last is known.
            S_TCHK: begin
               if ((count_ff != '0) && (n_ff != stl_pkg::MAX_RESULTS) && alu_flags.lt_half) begin
                  if (pend_valid_ff) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_kind_ff   <= stl_pkg::KIND_EVENT;
                     rsp_which_ff  <= 4'(pend_id_ff);
                     rsp_rp_ff     <= '0;
                     rsp_failed_ff <= 1'b0;
                     rsp_last_ff   <= 1'b0;
                  end
                  pend_valid_ff      <= 1'b1;
                  pend_id_ff         <= head_ff;
                  n_ff               <= n_ff + 1'b1;
                  head_ff            <= rd_next;
                  count_ff           <= count_ff - CW'(1);
                  active_ff[head_ff] <= 1'b0;
                  if (periodic_ff[head_ff]) begin
                     id_ff        <= head_ff;
                     from_tick_ff <= 1'b1;
                     state_ff     <= S_DL;
                  end
               end else begin
                  if (pend_valid_ff) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_kind_ff   <= stl_pkg::KIND_EVENT;
                     rsp_which_ff  <= 4'(pend_id_ff);
                     rsp_rp_ff     <= '0;
                     rsp_failed_ff <= 1'b0;
                     rsp_last_ff   <= 1'b1;
                  end
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Port drive.
   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_which_timer = rsp_which_ff;
   assign rsp_read_period = rsp_rp_ff;
   assign rsp_failed      = rsp_failed_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire

// ===== rtl/core/stl_checker.sv =====
// Port-level checks of the sorted timer list and their bind.
`default_nettype none
module stl_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic [2:0]  req_cmd,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_kind,
   input wire logic        rsp_failed,
   input wire logic        rsp_last
);

   // A command response is always the only beat of its command.
   a_resp_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == stl_pkg::KIND_RESP) |-> rsp_last)
      else $error("command response without last");

   // Expiry beats never report failure.
   a_event_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == stl_pkg::KIND_EVENT) |-> !rsp_failed)
      else $error("expiry beat marked failed");

   // A command either answers at once or keeps the block busy.
   a_cmd_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd != stl_pkg::CMD_TICK) |=> busy || rsp_valid)
      else $error("command neither answered nor in progress");

   // A tick always keeps the block busy while it checks the head.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == stl_pkg::CMD_TICK) |=> busy)
      else $error("tick not processed");

   // No beat comes straight out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("beat right after reset");

endmodule

bind sorted_timer_list stl_checker u_stl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .req_cmd    (req_cmd),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_kind   (rsp_kind),
   .rsp_failed (rsp_failed),
   .rsp_last   (rsp_last)
);
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the sorted timer list: queued commands, a list model and a beat checker.
`timescale 1ns / 1ps
module tb;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  id;
      logic [31:0] pv;
   } command_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  which;
      logic [30:0] rp;
      logic        failed;
      logic        last;
   } beat_type;

   localparam logic [31:0] HALF_SPAN = 32'h7FFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [2:0]  req_cmd = stl_pkg::CMD_TICK;
   logic [3:0]  req_timer_id = '0;
   logic [31:0] req_period_value = '0;
   logic        busy, rsp_valid, rsp_kind, rsp_failed, rsp_last;
   logic [3:0]  rsp_which_timer;
   logic [30:0] rsp_read_period;

   command_type pending_cmds[$];
   beat_type    expected_beats[$];
   int          error_count = 0;
   bit          stimulus_done = 1'b0;
   bit          took_beat = 1'b0;
   int          gap_left = 0;

   // Timer state mirrored from the block's behavior.
   logic [31:0] model_now;
   logic [31:0] model_deadline[16];
   logic [30:0] model_period[16];
   bit          model_active[16];
   bit          model_periodic[16];
   int          model_order[$];

   sorted_timer_list i_dut (
      .clock(clock), .reset(reset), .start(start), .req_cmd(req_cmd),
      .req_timer_id(req_timer_id), .req_period_value(req_period_value),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_kind(rsp_kind),
      .rsp_which_timer(rsp_which_timer), .rsp_read_period(rsp_read_period),
      .rsp_failed(rsp_failed), .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   function automatic void drop_timer(int t);
      foreach (model_order[k]) begin
         if (model_order[k] == t) begin
            model_order.delete(k);
            return;
         end
      end
   endfunction

   // Insert after every timer whose deadline is equal or earlier.
   function automatic void arm_timer(int t);
      logic [31:0] p;
      logic [31:0] d;
      int          pos;
      if (model_active[t]) drop_timer(t);
      p = {1'b0, model_period[t]};
      if (p == 0) p = 1;
      if (p > HALF_SPAN) p = HALF_SPAN;
      model_deadline[t] = model_now + p;
      pos = model_order.size();
      foreach (model_order[k]) begin
         d = model_deadline[model_order[k]] - model_deadline[t];
         if (d != 0 && d < HALF_SPAN) begin
            pos = k;
            break;
         end
      end
      model_order.insert(pos, t);
      model_active[t] = 1'b1;
   endfunction

   // Work out the beats that one accepted command causes.
   function automatic void predict_beats(command_type c);
      beat_type    b;
      beat_type    outs[$];
      int          t;
      logic [31:0] pv;
      b = '0;
      if (c.cmd == stl_pkg::CMD_TICK) begin
         model_now = model_now + 1;
         while (model_order.size() > 0 && outs.size() < stl_pkg::MAX_RESULTS) begin
            t = model_order[0];
            if (model_now - model_deadline[t] >= HALF_SPAN) break;
            void'(model_order.pop_front());
            model_active[t] = 1'b0;
            b = '0;
            b.kind = stl_pkg::KIND_EVENT;
            b.which = 4'(t);
            outs.push_back(b);
            if (model_periodic[t]) arm_timer(t);
         end
      end else begin
         b.kind = stl_pkg::KIND_RESP;
         b.which = c.id;
         case (c.cmd)
            stl_pkg::CMD_START: arm_timer(c.id);
            stl_pkg::CMD_STOP: begin
               if (model_active[c.id]) begin
                  drop_timer(c.id);
                  model_active[c.id] = 1'b0;
               end else begin
                  b.failed = 1'b1;
               end
            end
            stl_pkg::CMD_SET_PER: begin
               pv = c.pv;
               if (pv == 0) pv = 1;
               if (pv > {1'b0, stl_pkg::PERIOD_MAX}) pv = {1'b0, stl_pkg::PERIOD_MAX};
               model_period[c.id] = pv[30:0];
            end
            stl_pkg::CMD_READ_PER: b.rp = model_period[c.id];
            stl_pkg::CMD_ONE_SHOT: model_periodic[c.id] = 1'b0;
            stl_pkg::CMD_PERIODIC: model_periodic[c.id] = 1'b1;
            default: b.failed = 1'b1;
         endcase
         outs.push_back(b);
      end
      if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
      foreach (outs[k]) expected_beats.push_back(outs[k]);
   endfunction

   function automatic command_type make_cmd(logic [2:0] cmd, int id, logic [31:0] pv);
      command_type c;
      c.cmd = cmd;
      c.id = 4'(id);
      c.pv = pv;
      return c;
   endfunction

   // Driver: present each command at a falling edge after a random gap.
   always @(negedge clock) begin
      if (!reset) begin
         if (!start || took_beat) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               command_type c;
               c = pending_cmds.pop_front();
               req_cmd <= c.cmd;
               req_timer_id <= c.id;
               req_period_value <= c.pv;
               start <= 1'b1;
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            end else begin
               start <= 1'b0;
               stimulus_done <= 1'b1;
            end
         end
      end
   end

   // Acceptance and result monitor, sampled at the rising edge.
   always @(posedge clock) begin
      took_beat <= !reset && start && !busy;
      if (!reset) begin
         if (start && !busy) begin
            predict_beats(make_cmd(req_cmd, req_timer_id, req_period_value));
         end
         if (rsp_valid) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat kind=%0d timer=%0d", $realtime,
                        rsp_kind, rsp_which_timer);
               error_count++;
            end else begin
               beat_type e;
               beat_type a;
               e = expected_beats.pop_front();
               a = {rsp_kind, rsp_which_timer, rsp_read_period, rsp_failed, rsp_last};
               if (a != e) begin
                  $display({"%0t: beat mismatch expected kind=%0d timer=%0d period=%0d",
                            " failed=%0d last=%0d actual kind=%0d timer=%0d",
                            " period=%0d failed=%0d last=%0d"},
                           $realtime, e.kind, e.which, e.rp, e.failed, e.last,
                           a.kind, a.which, a.rp, a.failed, a.last);
                  error_count++;
               end
            end
         end
      end
   end

   // Fill the command queue: directed cases first, then random sequences.
   initial begin
      int r;
      model_now = '0;
      for (int i = 0; i < 16; i++) begin
         model_deadline[i] = '0;
         model_period[i] = '0;
         model_active[i] = 1'b0;
         model_periodic[i] = 1'b0;
      end
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_STOP, 0, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_READ_PER, 15, 32'hFFFF_FFFF));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_START, 0, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_TICK, 9, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_SET_PER, 1, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_SET_PER, 2, 32'hFFFF_FFFF));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_SET_PER, 3, 32'h8000_0000));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_READ_PER, 2, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_READ_PER, 1, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_START, 2, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_PERIODIC, 1, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_START, 1, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_START, 4, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_TICK, 0, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_TICK, 0, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_ONE_SHOT, 1, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_TICK, 0, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_STOP, 2, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_STOP, 2, 0));
      pending_cmds.push_back(make_cmd(stl_pkg::CMD_INVALID, 5, 32'h1234_5678));
      // Random part: mostly small periods so timers fire often.
      for (int i = 0; i < 300; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40) pending_cmds.push_back(make_cmd(stl_pkg::CMD_TICK,
               $urandom_range(0, 15), $urandom));
         else if (r < 60) pending_cmds.push_back(make_cmd(stl_pkg::CMD_START,
               $urandom_range(0, 15), $urandom));
         else if (r < 68) pending_cmds.push_back(make_cmd(stl_pkg::CMD_STOP,
               $urandom_range(0, 15), $urandom));
         else if (r < 80) pending_cmds.push_back(make_cmd(stl_pkg::CMD_SET_PER,
               $urandom_range(0, 15),
               ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6)));
         else if (r < 86) pending_cmds.push_back(make_cmd(stl_pkg::CMD_READ_PER,
               $urandom_range(0, 15), $urandom));
         else if (r < 91) pending_cmds.push_back(make_cmd(stl_pkg::CMD_ONE_SHOT,
               $urandom_range(0, 15), $urandom));
         else if (r < 98) pending_cmds.push_back(make_cmd(stl_pkg::CMD_PERIODIC,
               $urandom_range(0, 15), $urandom));
         else pending_cmds.push_back(make_cmd(stl_pkg::CMD_INVALID,
               $urandom_range(0, 15), $urandom));
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (stimulus_done && expected_beats.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_beats.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #10ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/stl_pkg.sv
rtl/core/stl_alu.sv
rtl/core/sorted_timer_list.sv
rtl/core/stl_checker.sv
test/tb.sv
